[hw/rtl/hmfp_pkg.sv]
// Shared types, character codes and helpers for the hex marker frame parser.
package hmfp_pkg;

  // Frame kind codes reported on the result channel
  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_KEYS    = 3'd1;
  localparam logic [2:0] KIND_FADER1  = 3'd2;
  localparam logic [2:0] KIND_FADER2  = 3'd3;
  localparam logic [2:0] KIND_CTRL    = 3'd4;
  localparam logic [2:0] KIND_DROPPED = 3'd5;

  // Start markers and terminators
  localparam logic [7:0] CH_KEYS_START = 8'h21;  // '!'
  localparam logic [7:0] CH_KEYS_END   = 8'h40;  // '@'
  localparam logic [7:0] CH_FAD1_START = 8'h23;  // '#'
  localparam logic [7:0] CH_FAD1_END   = 8'h24;  // '$'
  localparam logic [7:0] CH_FAD2_START = 8'h26;  // '&'
  localparam logic [7:0] CH_FAD2_END   = 8'h2A;  // '*'
  localparam logic [7:0] CH_CTRL_START = 8'h28;  // '('
  localparam logic [7:0] CH_CTRL_END   = 8'h29;  // ')'

  // Digit range bounds
  localparam logic [7:0] CH_DIG_0 = 8'h30;  // '0'
  localparam logic [7:0] CH_DIG_9 = 8'h39;  // '9'
  localparam logic [7:0] CH_UC_A  = 8'h41;  // 'A'
  localparam logic [7:0] CH_UC_F  = 8'h46;  // 'F'
  localparam logic [7:0] CH_LC_A  = 8'h61;  // 'a'
  localparam logic [7:0] CH_LC_F  = 8'h66;  // 'f'

  // History depth: marker plus up to four digits
  localparam int unsigned HIST_DEPTH = 5;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] nibble_t;

  // Hex digit value; anything that is not a hex digit gives its low nibble
  function automatic nibble_t nibble_of(input byte_t c);
    byte_t v;
    v = c;
    if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
      v = c - CH_DIG_0;
    end else if (c >= CH_UC_A && c <= CH_UC_F) begin
      v = c - CH_UC_A + 8'd10;
    end else if (c >= CH_LC_A && c <= CH_LC_F) begin
      v = c - CH_LC_A + 8'd10;
    end
    return v[3:0];
  endfunction

endpackage

[hw/rtl/hex_marker_frame_parser.sv]
// Top level of the hex marker frame parser: byte history, position counter, result register.
//
// Takes one received ASCII byte per request and returns exactly one result per byte:
// '!'dddd'@' gives kind 1 with a 16-bit key bitmap, '#'dd'$', '&'dd'*' and '('dd')' give
// kinds 2, 3 and 4 with an 8-bit value in the low byte, a terminator whose marker and
// digits are not in place gives kind 5 (dropped frame), and any other byte gives kind 0.
// Digits that are not hex contribute their low nibble. Every terminator clears the
// history and the position counter; other bytes shift in and advance the counter, which
// wraps to zero at WRAP_LENGTH. Each accepted byte's result is registered, and a new byte is
// accepted every cycle as long as the result register is empty or being drained in the same
// cycle; throughput is one byte per clock.
module hex_marker_frame_parser #(
  parameter int unsigned WRAP_LENGTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_frame_kind,
  output logic [15:0] out_frame_value
);

  localparam int unsigned CNT_W = $clog2(WRAP_LENGTH);

  hmfp_pkg::byte_t   hist_r [hmfp_pkg::HIST_DEPTH];
  logic [CNT_W-1:0]  cnt_r;
  logic              out_valid_r;
  logic [2:0]        kind_r;
  logic [15:0]       value_r;

  logic              in_acc;
  logic              is_term;
  logic              frame_ok;
  logic              long_frame;
  hmfp_pkg::byte_t   start_ch;
  logic [2:0]        good_kind;
  logic [2:0]        kind_nxt;
  logic [15:0]       value_nxt;
  logic [CNT_W-1:0]  cnt_nxt;

  // Handshake: result register is free or drains this cycle
  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  // Terminator decode
  always_comb begin
    is_term    = 1'b1;
    long_frame = 1'b0;
    start_ch   = hmfp_pkg::CH_KEYS_START;
    good_kind  = hmfp_pkg::KIND_NONE;
    unique case (in_rx_byte)
      hmfp_pkg::CH_KEYS_END: begin
        long_frame = 1'b1;
        start_ch   = hmfp_pkg::CH_KEYS_START;
        good_kind  = hmfp_pkg::KIND_KEYS;
      end
      hmfp_pkg::CH_FAD1_END: begin
        start_ch  = hmfp_pkg::CH_FAD1_START;
        good_kind = hmfp_pkg::KIND_FADER1;
      end
      hmfp_pkg::CH_FAD2_END: begin
        start_ch  = hmfp_pkg::CH_FAD2_START;
        good_kind = hmfp_pkg::KIND_FADER2;
      end
      hmfp_pkg::CH_CTRL_END: begin
        start_ch  = hmfp_pkg::CH_CTRL_START;
        good_kind = hmfp_pkg::KIND_CTRL;
      end
      default: begin
        is_term = 1'b0;
      end
    endcase
  end

  // Marker check: enough bytes since last terminator and marker in its slot
  always_comb begin
    if (long_frame) begin
      frame_ok = (cnt_r >= CNT_W'(5)) && (hist_r[4] == start_ch);
    end else begin
      frame_ok = (cnt_r >= CNT_W'(3)) && (hist_r[2] == start_ch);
    end
  end

  // Result selection and value assembly
  always_comb begin
    kind_nxt  = hmfp_pkg::KIND_NONE;
    value_nxt = '0;
    if (is_term) begin
      if (frame_ok) begin
        kind_nxt = good_kind;
        if (long_frame) begin
          value_nxt = {hmfp_pkg::nibble_of(hist_r[3]), hmfp_pkg::nibble_of(hist_r[2]),
                       hmfp_pkg::nibble_of(hist_r[1]), hmfp_pkg::nibble_of(hist_r[0])};
        end else begin
          value_nxt = {8'h00, hmfp_pkg::nibble_of(hist_r[1]),
                       hmfp_pkg::nibble_of(hist_r[0])};
        end
      end else begin
        kind_nxt = hmfp_pkg::KIND_DROPPED;
      end
    end
  end

  // Position counter with wrap
  always_comb begin
    if (is_term || cnt_r == CNT_W'(WRAP_LENGTH - 1)) begin
      cnt_nxt = '0;
    end else begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  // History and counter update on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < hmfp_pkg::HIST_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
      cnt_r <= '0;
    end else if (in_acc) begin
      cnt_r <= cnt_nxt;
      if (is_term) begin
        for (int i = 0; i < hmfp_pkg::HIST_DEPTH; i++) begin
          hist_r[i] <= '0;
        end
      end else begin
        for (int i = hmfp_pkg::HIST_DEPTH - 1; i > 0; i--) begin
          hist_r[i] <= hist_r[i-1];
        end
        hist_r[0] <= in_rx_byte;
      end
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r  <= kind_nxt;
      value_r <= value_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_kind  = kind_r;
  assign out_frame_value = value_r;

endmodule
